/* design/tc_pkg.sv */
`default_nettype none
package tc_pkg;

  // Default coordinate width of the input points
  localparam int unsigned COORD_WIDTH_DEF = 32;
  // Quotient bits resolved by the divider chain; a larger quotient always saturates
  localparam int unsigned QBITS = 66;
  // Width of the centre coordinates
  localparam int unsigned CENTER_W = 64;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COINC = 2'd1,
    ST_COLIN = 2'd2,
    ST_SAT   = 2'd3
  } tc_status_e;

  // Flags that travel with a transaction down the pipe
  typedef struct packed {
    logic coinc;
    logic colin;
    logic xneg;
    logic yneg;
    logic ovfx;
    logic ovfy;
  } tc_ctrl_t;

endpackage
`default_nettype wire

/* design/tc_front.sv */
`default_nettype none
module tc_front #(
  parameter int unsigned COORD_WIDTH = tc_pkg::COORD_WIDTH_DEF,
  parameter int unsigned QB          = tc_pkg::QBITS,
  parameter int unsigned DMW         = 2 * (2 * (COORD_WIDTH + 1)) + 2 - (COORD_WIDTH + 1) * 2,
  parameter int unsigned RW          = DMW + QB
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic [COORD_WIDTH-1:0] ax_i,
  input  wire logic [COORD_WIDTH-1:0] ay_i,
  input  wire logic [COORD_WIDTH-1:0] bx_i,
  input  wire logic [COORD_WIDTH-1:0] by_i,
  input  wire logic [COORD_WIDTH-1:0] px_i,
  input  wire logic [COORD_WIDTH-1:0] py_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output logic [COORD_WIDTH-1:0]      ax_o,
  output logic [COORD_WIDTH-1:0]      ay_o,
  output logic [RW-1:0]               remx_o,
  output logic [RW-1:0]               remy_o,
  output logic [DMW-1:0]              dmag_o,
  output tc_pkg::tc_ctrl_t            ctrl_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned DETW = PW + 1;
  localparam int unsigned PPW  = 2 * DW + 1;
  localparam int unsigned NW   = 3 * DW + 2;

  logic [6:1] v_q;
  logic [7:1] en;

  // Stage enables: a stage loads when empty or when its content moves on
  assign en[7] = ready_i;
  for (genvar k = 1; k <= 6; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end
  assign ready_o = en[1];
  assign valid_o = v_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= valid_i;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: relative vectors and coincidence
  logic [W-1:0]         ax1_q, ay1_q;
  logic signed [DW-1:0] ux1_q, uy1_q, vx1_q, vy1_q;
  logic                 coinc1_q;
  logic                 coinc_d;

  assign coinc_d = (ax_i == bx_i && ay_i == by_i) || (ax_i == px_i && ay_i == py_i) ||
                   (bx_i == px_i && by_i == py_i);

  always_ff @(posedge clk_i) begin
    if (en[1] && valid_i) begin
      ax1_q    <= ax_i;
      ay1_q    <= ay_i;
      ux1_q    <= {bx_i[W-1], bx_i} - {ax_i[W-1], ax_i};
      uy1_q    <= {by_i[W-1], by_i} - {ay_i[W-1], ay_i};
      vx1_q    <= {px_i[W-1], px_i} - {ax_i[W-1], ax_i};
      vy1_q    <= {py_i[W-1], py_i} - {ay_i[W-1], ay_i};
      coinc1_q <= coinc_d;
    end
  end

  // Stage 2: cross and square products
  logic [W-1:0]         ax2_q, ay2_q;
  logic signed [DW-1:0] ux2_q, uy2_q, vx2_q, vy2_q;
  logic signed [PW-1:0] puv_q, pyx_q, puu_q, pyy_q, pxx_q, pvv_q;
  logic                 coinc2_q;

  always_ff @(posedge clk_i) begin
    if (en[2] && v_q[1]) begin
      ax2_q    <= ax1_q;
      ay2_q    <= ay1_q;
      ux2_q    <= ux1_q;
      uy2_q    <= uy1_q;
      vx2_q    <= vx1_q;
      vy2_q    <= vy1_q;
      puv_q    <= ux1_q * vy1_q;
      pyx_q    <= uy1_q * vx1_q;
      puu_q    <= ux1_q * ux1_q;
      pyy_q    <= uy1_q * uy1_q;
      pxx_q    <= vx1_q * vx1_q;
      pvv_q    <= vy1_q * vy1_q;
      coinc2_q <= coinc1_q;
    end
  end

  // Stage 3: determinant and squared lengths
  logic [W-1:0]         ax3_q, ay3_q;
  logic signed [DW-1:0] ux3_q, uy3_q, vx3_q, vy3_q;
  logic [DETW-1:0]      det3_q;
  logic [PW-1:0]        su3_q, sv3_q;
  logic                 coinc3_q;

  always_ff @(posedge clk_i) begin
    if (en[3] && v_q[2]) begin
      ax3_q    <= ax2_q;
      ay3_q    <= ay2_q;
      ux3_q    <= ux2_q;
      uy3_q    <= uy2_q;
      vx3_q    <= vx2_q;
      vy3_q    <= vy2_q;
      det3_q   <= {puv_q[PW-1], puv_q} - {pyx_q[PW-1], pyx_q};
      su3_q    <= puu_q + pyy_q;
      sv3_q    <= pxx_q + pvv_q;
      coinc3_q <= coinc2_q;
    end
  end

  // Stage 4: partial products of the numerators, lengths split in halves
  logic [W-1:0]          ax4_q, ay4_q;
  logic signed [PPW-1:0] pp_q [8];
  logic [DETW-1:0]       det4_q;
  logic                  coinc4_q, colin4_q;
  logic signed [DW:0]    sul, suh, svl, svh;

  assign sul = {1'b0, su3_q[DW-1:0]};
  assign suh = {1'b0, su3_q[PW-1:DW]};
  assign svl = {1'b0, sv3_q[DW-1:0]};
  assign svh = {1'b0, sv3_q[PW-1:DW]};

  always_ff @(posedge clk_i) begin
    if (en[4] && v_q[3]) begin
      ax4_q    <= ax3_q;
      ay4_q    <= ay3_q;
      pp_q[0]  <= vy3_q * suh;
      pp_q[1]  <= vy3_q * sul;
      pp_q[2]  <= uy3_q * svh;
      pp_q[3]  <= uy3_q * svl;
      pp_q[4]  <= ux3_q * svh;
      pp_q[5]  <= ux3_q * svl;
      pp_q[6]  <= vx3_q * suh;
      pp_q[7]  <= vx3_q * sul;
      det4_q   <= det3_q;
      coinc4_q <= coinc3_q;
      colin4_q <= (det3_q == '0);
    end
  end

  // Stage 5: numerators and doubled determinant
  logic [W-1:0]         ax5_q, ay5_q;
  logic signed [NW-1:0] nx5_q, ny5_q;
  logic [DMW-1:0]       d5_q;
  logic                 coinc5_q, colin5_q;
  logic signed [NW-1:0] ppe [8];

  for (genvar k = 0; k < 8; k++) begin : g_ext
    assign ppe[k] = pp_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (en[5] && v_q[4]) begin
      ax5_q    <= ax4_q;
      ay5_q    <= ay4_q;
      nx5_q    <= (ppe[0] <<< DW) + ppe[1] - (ppe[2] <<< DW) - ppe[3];
      ny5_q    <= (ppe[4] <<< DW) + ppe[5] - (ppe[6] <<< DW) - ppe[7];
      d5_q     <= {det4_q, 1'b0};
      coinc5_q <= coinc4_q;
      colin5_q <= colin4_q;
    end
  end

  // Stage 6: magnitudes, signs and range check of the quotient
  logic [NW-1:0]  nxm, nym;
  logic [DMW-1:0] dm;
  logic [RW:0]    dlim;

  assign nxm  = nx5_q[NW-1] ? -nx5_q : nx5_q;
  assign nym  = ny5_q[NW-1] ? -ny5_q : ny5_q;
  assign dm   = d5_q[DMW-1] ? -d5_q : d5_q;
  assign dlim = {1'b0, dm, {QB{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en[6] && v_q[5]) begin
      ax_o         <= ax5_q;
      ay_o         <= ay5_q;
      remx_o       <= RW'(nxm);
      remy_o       <= RW'(nym);
      dmag_o       <= dm;
      ctrl_o.coinc <= coinc5_q;
      ctrl_o.colin <= colin5_q;
      ctrl_o.xneg  <= nx5_q[NW-1] ^ d5_q[DMW-1];
      ctrl_o.yneg  <= ny5_q[NW-1] ^ d5_q[DMW-1];
      ctrl_o.ovfx  <= (RW+1)'(nxm) >= dlim;
      ctrl_o.ovfy  <= (RW+1)'(nym) >= dlim;
    end
  end

endmodule
`default_nettype wire

/* design/tc_div_cell.sv */
`default_nettype none
module tc_div_cell #(
  parameter int unsigned COORD_WIDTH = tc_pkg::COORD_WIDTH_DEF,
  parameter int unsigned QB          = tc_pkg::QBITS,
  parameter int unsigned DMW         = 2 * (COORD_WIDTH + 1) + 2,
  parameter int unsigned RW          = DMW + QB,
  parameter int unsigned K           = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic [COORD_WIDTH-1:0] ax_i,
  input  wire logic [COORD_WIDTH-1:0] ay_i,
  input  wire logic [RW-1:0]          remx_i,
  input  wire logic [RW-1:0]          remy_i,
  input  wire logic [QB-1:0]          qx_i,
  input  wire logic [QB-1:0]          qy_i,
  input  wire logic [DMW-1:0]         dmag_i,
  input  wire tc_pkg::tc_ctrl_t       ctrl_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output logic [COORD_WIDTH-1:0]      ax_o,
  output logic [COORD_WIDTH-1:0]      ay_o,
  output logic [RW-1:0]               remx_o,
  output logic [RW-1:0]               remy_o,
  output logic [QB-1:0]               qx_o,
  output logic [QB-1:0]               qy_o,
  output logic [DMW-1:0]              dmag_o,
  output tc_pkg::tc_ctrl_t            ctrl_o
);

  logic        en;
  logic        v_q;
  logic [RW:0] dsh, subx, suby;
  logic [QB-1:0] qxn, qyn;

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;

  // Trial subtraction of the divisor shifted to this quotient bit
  assign dsh  = (RW+1)'(dmag_i) << K;
  assign subx = {1'b0, remx_i} - dsh;
  assign suby = {1'b0, remy_i} - dsh;

  // Quotient with this cell's bit filled in
  always_comb begin
    qxn    = qx_i;
    qxn[K] = !subx[RW];
    qyn    = qy_i;
    qyn[K] = !suby[RW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      ax_o      <= ax_i;
      ay_o      <= ay_i;
      dmag_o    <= dmag_i;
      ctrl_o    <= ctrl_i;
      remx_o    <= subx[RW] ? remx_i : subx[RW-1:0];
      remy_o    <= suby[RW] ? remy_i : suby[RW-1:0];
      qx_o      <= qxn;
      qy_o      <= qyn;
    end
  end

endmodule
`default_nettype wire

/* design/tc_back.sv */
`default_nettype none
module tc_back #(
  parameter int unsigned COORD_WIDTH = tc_pkg::COORD_WIDTH_DEF,
  parameter int unsigned QB          = tc_pkg::QBITS,
  parameter int unsigned DMW         = 2 * (COORD_WIDTH + 1) + 2,
  parameter int unsigned RW          = DMW + QB
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           ready_o,
  input  wire logic [COORD_WIDTH-1:0]    ax_i,
  input  wire logic [COORD_WIDTH-1:0]    ay_i,
  input  wire logic [RW-1:0]             remx_i,
  input  wire logic [RW-1:0]             remy_i,
  input  wire logic [QB-1:0]             qx_i,
  input  wire logic [QB-1:0]             qy_i,
  input  wire logic [DMW-1:0]            dmag_i,
  input  wire tc_pkg::tc_ctrl_t          ctrl_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output tc_pkg::tc_status_e             status_o,
  output logic [tc_pkg::CENTER_W-1:0]    center_x_o,
  output logic [tc_pkg::CENTER_W-1:0]    center_y_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned CW = tc_pkg::CENTER_W;
  localparam int unsigned SW = QB + 3;

  logic v1_q, v2_q, en1, en2;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Stage 1: round to nearest, ties away from zero, and apply the sign
  logic [RW+1:0]      dext;
  logic [QB:0]        rqx, rqy;
  logic [W-1:0]       ax1_q, ay1_q;
  logic [QB+1:0]      sqx_q, sqy_q;
  tc_pkg::tc_ctrl_t   ctrl1_q;

  assign dext = (RW+2)'(dmag_i);
  assign rqx  = {1'b0, qx_i} + (QB+1)'({1'b0, remx_i, 1'b0} >= dext);
  assign rqy  = {1'b0, qy_i} + (QB+1)'({1'b0, remy_i, 1'b0} >= dext);

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      ax1_q   <= ax_i;
      ay1_q   <= ay_i;
      ctrl1_q <= ctrl_i;
      sqx_q   <= ctrl_i.xneg ? -{1'b0, rqx} : {1'b0, rqx};
      sqy_q   <= ctrl_i.yneg ? -{1'b0, rqy} : {1'b0, rqy};
    end
  end

  // Stage 2: add the first point, clamp to the output range and pick the status; degenerate input gives a zero centre
  logic [SW-1:0] sx, sy;
  logic          fitx, fity, satx, saty;
  logic [CW-1:0] cx, cy, lim_pos, lim_neg;

  assign sx = {{(SW-W){ax1_q[W-1]}}, ax1_q} + {sqx_q[QB+1], sqx_q};
  assign sy = {{(SW-W){ay1_q[W-1]}}, ay1_q} + {sqy_q[QB+1], sqy_q};
  assign fitx = (sx[SW-1:CW-1] == '0) || (sx[SW-1:CW-1] == '1);
  assign fity = (sy[SW-1:CW-1] == '0) || (sy[SW-1:CW-1] == '1);
  assign satx = ctrl1_q.ovfx || !fitx;
  assign saty = ctrl1_q.ovfy || !fity;
  assign lim_pos = {1'b0, {(CW-1){1'b1}}};
  assign lim_neg = {1'b1, {(CW-1){1'b0}}};

  always_comb begin
    if (ctrl1_q.ovfx) cx = ctrl1_q.xneg ? lim_neg : lim_pos;
    else if (!fitx)   cx = sx[SW-1] ? lim_neg : lim_pos;
    else              cx = sx[CW-1:0];
    if (ctrl1_q.ovfy) cy = ctrl1_q.yneg ? lim_neg : lim_pos;
    else if (!fity)   cy = sy[SW-1] ? lim_neg : lim_pos;
    else              cy = sy[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      priority if (ctrl1_q.coinc) begin
        status_o   <= tc_pkg::ST_COINC;
        center_x_o <= '0;
        center_y_o <= '0;
      end else if (ctrl1_q.colin) begin
        status_o   <= tc_pkg::ST_COLIN;
        center_x_o <= '0;
        center_y_o <= '0;
      end else begin
        status_o   <= (satx || saty) ? tc_pkg::ST_SAT : tc_pkg::ST_OK;
        center_x_o <= cx;
        center_y_o <= cy;
      end
    end
  end

endmodule
`default_nettype wire

/* design/triangle_circumcenter.sv */
// Channel | Handshake                     | Payload
// in      | in_valid_i / in_ready_o       | ax_i ay_i bx_i by_i px_i py_i
// out     | out_valid_o / out_ready_i     | status_o center_x_o center_y_o
//
// One transaction is taken per cycle while the output is not stalled; the row of
// divider cells resolves one quotient bit per cell.
// Front: six stages (differences, products, determinant, partial products,
// numerators, magnitudes). Back: rounding stage and the output register.
// Reset clears only the valid flags; the data registers are not reset.
// Every stage is elastic, so a stalled output fills the pipe before in_ready_o falls.
`default_nettype none
module triangle_circumcenter #(
  parameter int unsigned COORD_WIDTH = tc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] ax_i,
  input  wire logic [31:0] ay_i,
  input  wire logic [31:0] bx_i,
  input  wire logic [31:0] by_i,
  input  wire logic [31:0] px_i,
  input  wire logic [31:0] py_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [63:0]      center_x_o,
  output logic [63:0]      center_y_o
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned QB  = tc_pkg::QBITS;
  localparam int unsigned DMW = 2 * (W + 1) + 2;
  localparam int unsigned RW  = DMW + QB;

  // Chain links: index 0 is the front output, index QB the last cell output
  logic             v    [QB+1];
  logic             r    [QB+1];
  logic [W-1:0]     axc  [QB+1];
  logic [W-1:0]     ayc  [QB+1];
  logic [RW-1:0]    remx [QB+1];
  logic [RW-1:0]    remy [QB+1];
  logic [QB-1:0]    qx   [QB+1];
  logic [QB-1:0]    qy   [QB+1];
  logic [DMW-1:0]   dm   [QB+1];
  tc_pkg::tc_ctrl_t ctl  [QB+1];
  tc_pkg::tc_status_e st;

  assign qx[0] = '0;
  assign qy[0] = '0;

  tc_front #(.COORD_WIDTH(W), .QB(QB), .DMW(DMW), .RW(RW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .ax_i    (ax_i[W-1:0]),
    .ay_i    (ay_i[W-1:0]),
    .bx_i    (bx_i[W-1:0]),
    .by_i    (by_i[W-1:0]),
    .px_i    (px_i[W-1:0]),
    .py_i    (py_i[W-1:0]),
    .valid_o (v[0]),
    .ready_i (r[0]),
    .ax_o    (axc[0]),
    .ay_o    (ayc[0]),
    .remx_o  (remx[0]),
    .remy_o  (remy[0]),
    .dmag_o  (dm[0]),
    .ctrl_o  (ctl[0])
  );

  // Divider row, most significant quotient bit first
  for (genvar j = 0; j < QB; j++) begin : g_cell
    tc_div_cell #(.COORD_WIDTH(W), .QB(QB), .DMW(DMW), .RW(RW), .K(QB - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[j]),
      .ready_o (r[j]),
      .ax_i    (axc[j]),
      .ay_i    (ayc[j]),
      .remx_i  (remx[j]),
      .remy_i  (remy[j]),
      .qx_i    (qx[j]),
      .qy_i    (qy[j]),
      .dmag_i  (dm[j]),
      .ctrl_i  (ctl[j]),
      .valid_o (v[j+1]),
      .ready_i (r[j+1]),
      .ax_o    (axc[j+1]),
      .ay_o    (ayc[j+1]),
      .remx_o  (remx[j+1]),
      .remy_o  (remy[j+1]),
      .qx_o    (qx[j+1]),
      .qy_o    (qy[j+1]),
      .dmag_o  (dm[j+1]),
      .ctrl_o  (ctl[j+1])
    );
  end

  tc_back #(.COORD_WIDTH(W), .QB(QB), .DMW(DMW), .RW(RW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v[QB]),
    .ready_o    (r[QB]),
    .ax_i       (axc[QB]),
    .ay_i       (ayc[QB]),
    .remx_i     (remx[QB]),
    .remy_i     (remy[QB]),
    .qx_i       (qx[QB]),
    .qy_i       (qy[QB]),
    .dmag_i     (dm[QB]),
    .ctrl_i     (ctl[QB]),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .status_o   (st),
    .center_x_o (center_x_o),
    .center_y_o (center_y_o)
  );

  assign status_o = st;

  // Degenerate triangles give a zero centre
  a_coinc_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && st == tc_pkg::ST_COINC) |-> (center_x_o == '0 && center_y_o == '0))
    else $error("coincident result with nonzero centre");

  a_colin_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && st == tc_pkg::ST_COLIN) |-> (center_x_o == '0 && center_y_o == '0))
    else $error("collinear result with nonzero centre");

  // A stalled result is held by the output register
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(center_x_o) && $stable(st)))
    else $error("stalled result changed");

  // An empty output stage never blocks the input side
  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v[0] && !out_valid_o) |-> in_ready_o)
    else $error("input stalled with empty pipe ends");

endmodule
`default_nettype wire

/* dv/tb_triangle_circumcenter.sv */
`default_nettype none
module tb_triangle_circumcenter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1880;
  localparam int CALM_TAIL  = 300;
  localparam int DRAIN_CYC  = 200;

  typedef struct {
    tc_pkg::tc_status_e status;
    logic [63:0]  cx;
    logic [63:0]  cy;
  } centre_t;

  // Scoreboard: works out the expected centre per transaction and checks results
  class centre_board;
    centre_t expq[$];
    int      errors;
    int      seen;

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at result %0d: %s got %h want %h", seen, what, got, want);
      errors++;
    endtask

    function centre_t predict(logic signed [31:0] ax, logic signed [31:0] ay,
                              logic signed [31:0] bx, logic signed [31:0] by,
                              logic signed [31:0] px, logic signed [31:0] py);
      logic signed [127:0] a_x, a_y, ux, uy, vx, vy, det, dd, su, sv, nx, ny;
      logic signed [127:0] ccx, ccy;
      centre_t r;
      r.status = tc_pkg::ST_OK;
      r.cx = '0;
      r.cy = '0;
      if ((ax == bx && ay == by) || (ax == px && ay == py) || (bx == px && by == py)) begin
        r.status = tc_pkg::ST_COINC;
        return r;
      end
      a_x = ax;
      a_y = ay;
      ux = bx;
      ux = ux - a_x;
      uy = by;
      uy = uy - a_y;
      vx = px;
      vx = vx - a_x;
      vy = py;
      vy = vy - a_y;
      det = ux * vy - uy * vx;
      if (det == 0) begin
        r.status = tc_pkg::ST_COLIN;
        return r;
      end
      dd = det + det;
      su = ux * ux + uy * uy;
      sv = vx * vx + vy * vy;
      nx = vy * su - uy * sv;
      ny = ux * sv - vx * su;
      ccx = a_x + rdiv(nx, dd);
      ccy = a_y + rdiv(ny, dd);
      r.cx = sat64(ccx, r.status);
      r.cy = sat64(ccy, r.status);
      return r;
    endfunction

    // Quotient rounded to nearest, ties away from zero
    function logic signed [127:0] rdiv(logic signed [127:0] n, logic signed [127:0] d);
      logic [127:0] nm, dm, q, rm;
      nm = n < 0 ? -n : n;
      dm = d < 0 ? -d : d;
      q  = nm / dm;
      rm = nm % dm;
      if ((rm << 1) >= dm) q = q + 1;
      return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function logic [63:0] sat64(logic signed [127:0] v, inout tc_pkg::tc_status_e st);
      logic signed [127:0] hi, lo;
      hi = 128'sh7FFF_FFFF_FFFF_FFFF;
      lo = -hi - 1;
      if (v > hi) begin
        st = tc_pkg::ST_SAT;
        return hi[63:0];
      end
      if (v < lo) begin
        st = tc_pkg::ST_SAT;
        return lo[63:0];
      end
      return v[63:0];
    endfunction

    function void note(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                       logic [31:0] by, logic [31:0] px, logic [31:0] py);
      expq.push_back(predict(ax, ay, bx, by, px, py));
    endfunction

    task check(logic [1:0] st, logic [63:0] cx, logic [63:0] cy);
      centre_t e;
      seen++;
      if (expq.size() == 0) begin
        $display("unexpected result %0d: status %0d", seen, st);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (st != e.status) report("status", st, e.status);
      if (cx != e.cx) report("center_x", cx, e.cx);
      if (cy != e.cy) report("center_y", cy, e.cy);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic [31:0] ax_i = '0, ay_i = '0, bx_i = '0, by_i = '0, px_i = '0, py_i = '0;
  logic        in_ready_o, out_valid_o;
  logic [1:0]  status_o;
  logic [63:0] center_x_o, center_y_o;
  bit          calm = 1'b0;

  centre_board sb = new();

  triangle_circumcenter dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .ax_i, .ay_i, .bx_i, .by_i, .px_i, .py_i,
    .out_valid_o, .out_ready_i, .status_o, .center_x_o, .center_y_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Offer one transaction, hold it until taken, and outside the calm tail sometimes drop valid for a random gap
  task automatic send(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                      logic [31:0] by, logic [31:0] px, logic [31:0] py);
    in_valid_i <= 1'b1;
    ax_i <= ax;
    ay_i <= ay;
    bx_i <= bx;
    by_i <= by;
    px_i <= px;
    py_i <= py;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(ax, ay, bx, by, px, py);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 4000) - 2000;
      3:    return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 200000) - 100000;
    endcase
  endfunction

  // Random triangle: mostly genuine, some coincident or collinear
  task automatic send_random();
    logic [31:0] ax, ay, bx, by, px, py;
    int k;
    ax = pick_coord();
    ay = pick_coord();
    bx = pick_coord();
    by = pick_coord();
    px = pick_coord();
    py = pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        if ($urandom_range(0, 1)) begin
          px = ax;
          py = ay;
        end else begin
          bx = px;
          by = py;
        end
      end
      1: begin
        ax = $urandom_range(0, 20000) - 10000;
        ay = $urandom_range(0, 20000) - 10000;
        bx = ax + $urandom_range(0, 2000) - 1000;
        by = ay + $urandom_range(0, 2000) - 1000;
        k  = $urandom_range(0, 20) - 10;
        px = ax + k * (bx - ax);
        py = ay + k * (by - ay);
      end
      2: begin
        // nearly collinear, large centre
        px = bx + (bx - ax);
        py = by + (by - ay) + $urandom_range(0, 2) - 1;
      end
      default: ;
    endcase
    send(ax, ay, bx, by, px, py);
  endtask

  // Result side, with random stall bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check(status_o, center_x_o, center_y_o);
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 9);
      out_ready_i <= (stall == 0) && rst_ni;
    end
  end

  initial begin
    #1ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [31:0] MINC = 32'h8000_0000;
    int waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, coincident, collinear, rounding and saturation
    send(0, 0, 256, 0, 0, 256);
    send(0, 0, 3, 0, 0, 1);
    send(0, 0, -3, 0, 0, -1);
    send(0, 0, 1, 0, 0, 1);
    send(5, 5, 5, 5, 9, 1);
    send(5, 5, 9, 1, 5, 5);
    send(9, 1, 5, 5, 5, 5);
    send(7, 7, 7, 7, 7, 7);
    send(0, 0, 1, 1, 2, 2);
    send(MINC, MINC, MAXC, MAXC, 0, 0);
    send(MINC, MINC, MAXC, MINC, MINC, MAXC);
    send(MAXC, MAXC, MINC, MAXC, MAXC, MINC);
    send(MINC, MINC, MAXC, MAXC, MAXC, MAXC - 1);
    send(MINC, 0, 0, 1, MAXC, 0);
    send(MINC, MINC, MINC + 1, MINC + 1, MAXC, MAXC);
    send(MINC, MAXC, MAXC, MINC, 0, 1);
    send(MINC, MINC, MAXC, MAXC - 1, MAXC - 1, MAXC - 2);
    send(-100, 37, 250, -81, 13, 999);
    send(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1, 1);
    send(MAXC, 0, MINC, 0, 0, 1);

    // Hold off until the pipe is empty
    in_valid_i <= 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - CALM_TAIL) calm = 1'b1;
      send_random();
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.expq.size() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
